// ===== sv/ble_sensor_advert_decoder_defines.svh =====
// Assertion macros for the decoder's checker file.
`ifndef BLE_SENSOR_ADVERT_DECODER_DEFINES_SVH
`define BLE_SENSOR_ADVERT_DECODER_DEFINES_SVH

// Property checked in the same cycle, ignored while reset is held.
`define BSAD_ASSERT_SAME(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bsad: same-cycle check failed");

// Antecedent in one cycle, consequent in the next.
`define BSAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bsad: next-cycle check failed");

`endif

// ===== sv/bsad_pkg.sv =====
// Types, identifiers and constants of the sensor advertisement decoder.
`default_nettype none

package bsad_pkg;

    localparam logic [15:0] ID_PACKED_1 = 16'hEC88;
    localparam logic [15:0] ID_PACKED_2 = 16'h0001;
    localparam logic [15:0] ID_LE16_3   = 16'h8801;

    localparam int WIN_BYTES = 5;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNKNOWN     = 2'd1,
        ST_SHORT       = 2'd2,
        ST_IMPLAUSIBLE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LAYOUT_PACKED1 = 2'd0,
        LAYOUT_PACKED2 = 2'd1,
        LAYOUT_LE16    = 2'd2
    } layout_t;

    // Plausibility limits on the raw fields.
    localparam logic [22:0] PK_POS_MAX  = 23'd800000;
    localparam logic [22:0] PK_NEG_MAX  = 23'd400000;
    localparam logic signed [15:0] LE_T_MIN = -16'sd4000;
    localparam logic signed [15:0] LE_T_MAX = 16'sd8000;
    localparam logic [15:0] LE_H_MAX    = 16'd10000;
    localparam logic [7:0]  BATT_MAX    = 8'd100;

    // Reciprocal multipliers: floor(x*K >> S) == floor(x/d) while x*(K*d - 2^S) < 2^S.
    localparam logic [20:0] DIV100_K  = 21'd1342178;   // x < 2^20 + 50, S = 27
    localparam int          DIV100_S  = 27;
    localparam logic [20:0] DIV1000_K = 21'd1073742;   // x < 2^20, S = 30
    localparam int          DIV1000_S = 30;
    localparam logic [13:0] DIV10_K   = 14'd13108;     // x < 2^14, S = 17
    localparam int          DIV10_S   = 17;

    // Decode job handed from the capture side to the decode logic.
    typedef struct packed {
        logic       known;
        layout_t    layout;
        logic [7:0] len;
    } job_t;

    typedef struct packed {
        status_t           status;
        logic signed [13:0] temp_centi;
        logic [9:0]        humidity_tenths;
        logic [6:0]        battery_percent;
        logic              battery_present;
        logic [1:0]        layout;
    } result_t;

    // Window offset of each layout.
    function automatic logic [7:0] layout_offset(input layout_t lay);
        logic [7:0] off;
        unique case (lay)
            LAYOUT_PACKED1: off = 8'd1;
            LAYOUT_PACKED2: off = 8'd2;
            LAYOUT_LE16:    off = 8'd3;
            default:        off = 8'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bsad_decode.sv =====
// Field decode, range checks and status for one finished packet.
`default_nettype none

module bsad_decode
    import bsad_pkg::*;
(
    input  wire job_t       job,
    input  wire logic [7:0] win [WIN_BYTES],
    output result_t         res
);

    // packed sign-magnitude layout
    logic [22:0] pk_mag;
    logic        pk_neg;
    logic        pk_bad;
    logic [20:0] pk_tnum;
    logic [41:0] pk_tprod;
    logic [13:0] pk_tq;
    logic [13:0] pk_temp;
    logic [19:0] pk_v20;
    logic [40:0] pk_hprod;
    logic [9:0]  pk_hq;
    logic [19:0] pk_hrem;
    logic [7:0]  pk_off;
    logic        pk_short;
    logic        pk_bpres;
    logic [7:0]  pk_batt;

    // little-endian layout
    logic signed [15:0] le_t;
    logic [15:0] le_h;
    logic        le_bad;
    logic [13:0] le_hnum;
    logic [27:0] le_hprod;
    logic [9:0]  le_hq;
    logic        le_short;
    logic        le_bpres;
    logic [7:0]  le_batt;

    always_comb begin
        pk_neg   = win[0][7];
        pk_mag   = {win[0][6:0], win[1], win[2]};
        pk_bad   = pk_neg ? (pk_mag > PK_NEG_MAX) : (pk_mag > PK_POS_MAX);
        pk_v20   = pk_mag[19:0];
        pk_tnum  = {1'b0, pk_v20} + 21'd50;
        pk_tprod = pk_tnum * DIV100_K;
        pk_tq    = pk_tprod[DIV100_S +: 14];
        pk_temp  = pk_neg ? (14'd0 - pk_tq) : pk_tq;
        pk_hprod = pk_v20 * DIV1000_K;
        pk_hq    = pk_hprod[DIV1000_S +: 10];
        pk_hrem  = pk_v20 - 20'(pk_hq * 20'd1000);
        pk_off   = layout_offset(job.layout);
        pk_short = job.len < (pk_off + 8'd3);
        pk_bpres = job.len > (pk_off + 8'd3);
        pk_batt  = pk_bpres ? win[3] : 8'd0;

        le_t     = $signed({win[1], win[0]});
        le_h     = {win[3], win[2]};
        le_bad   = (le_t < LE_T_MIN) || (le_t > LE_T_MAX) || (le_h > LE_H_MAX);
        le_hnum  = le_h[13:0] + 14'd5;
        le_hprod = le_hnum * DIV10_K;
        le_hq    = le_hprod[DIV10_S +: 10];
        le_short = job.len < 8'd7;
        le_bpres = job.len > 8'd7;
        le_batt  = le_bpres ? win[4] : 8'd0;
    end

    always_comb begin
        res = '0;
        res.status = ST_OK;
        if (!job.known) begin
            res.status = ST_UNKNOWN;
        end else begin
            res.layout = job.layout;
            unique case (job.layout)
                LAYOUT_PACKED1, LAYOUT_PACKED2: begin
                    if (pk_short) begin
                        res.status = ST_SHORT;
                    end else if (pk_bad || pk_batt > BATT_MAX) begin
                        res.status = ST_IMPLAUSIBLE;
                    end else begin
                        res.temp_centi      = $signed(pk_temp);
                        res.humidity_tenths = pk_hrem[9:0];
                        res.battery_percent = pk_batt[6:0];
                        res.battery_present = pk_bpres;
                    end
                end
                LAYOUT_LE16: begin
                    if (le_short) begin
                        res.status = ST_SHORT;
                    end else if (le_bad || le_batt > BATT_MAX) begin
                        res.status = ST_IMPLAUSIBLE;
                    end else begin
                        res.temp_centi      = le_t[13:0];
                        res.humidity_tenths = le_hq;
                        res.battery_percent = le_batt[6:0];
                        res.battery_present = le_bpres;
                    end
                end
                default: begin
                    res.status = ST_UNKNOWN;
                    res.layout = 2'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ble_sensor_advert_decoder.sv =====
// Top level of the sensor advertisement decoder: byte capture, job stage and result register.
//
//  channel | dir | tdata                        | tuser               | tlast
//  --------+-----+------------------------------+---------------------+-----------
//  s_      | in  | payload byte                 | manufacturer id     | final byte
//  m_      | out | temp, humidity, battery, pres| status, layout      | -
//
// One payload beat is taken per cycle while s_tready is high, with no gaps between packets.
// A final beat loads a decode job into the job stage; the result register takes
// the decoded result once m_ is free, and that raises m_tvalid.
// The window bytes and byte count are updated at the accepting edge; decode
// reads the window in the following cycle, before any later beat can land.
// While a result waits on m_tready, one further packet may complete into the
// job stage; only when both are held does s_tready drop.
// aresetn (synchronous) clears the byte count and both valid flags; no
// clearing pass, the window bytes need none.
`default_nettype none

module ble_sensor_advert_decoder
    import bsad_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  wire logic [15:0] s_tuser,   // [15:0] maker_id
    input  wire logic        s_tlast,   // final_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [13:0] temp_centi, [23:14] humidity_tenths,
                                        // [30:24] battery_percent, [31] battery_present
    output logic [3:0]       m_tuser    // [1:0] status, [3:2] layout
);

    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] win_reg [WIN_BYTES];
    logic       job_vld_reg, job_vld_next;
    job_t       job_reg, job_next;
    logic       m_vld_reg, m_vld_next;
    result_t    res_reg;
    result_t    dec_res;

    logic       s_beat;
    logic       out_free;
    logic       id_known;
    layout_t    id_layout;
    logic [7:0] id_off;
    logic [7:0] rel_pos;
    logic       win_hit;
    logic [7:0] len_sat;

    assign out_free = !m_vld_reg || m_tready;
    assign s_tready = !job_vld_reg || out_free;
    assign s_beat   = s_tvalid && s_tready;

    // manufacturer id picks the layout of the current beat
    always_comb begin
        id_known  = 1'b1;
        id_layout = LAYOUT_PACKED1;
        unique if (s_tuser == ID_PACKED_1) begin
            id_layout = LAYOUT_PACKED1;
        end else if (s_tuser == ID_PACKED_2) begin
            id_layout = LAYOUT_PACKED2;
        end else if (s_tuser == ID_LE16_3) begin
            id_layout = LAYOUT_LE16;
        end else begin
            id_known = 1'b0;
        end
        id_off  = layout_offset(id_layout);
        rel_pos = byte_count_reg - id_off;
        win_hit = id_known && (byte_count_reg >= id_off) && (rel_pos < 8'(WIN_BYTES));
    end

    // saturating length including this beat
    assign len_sat = (byte_count_reg == 8'hFF) ? 8'hFF : (byte_count_reg + 8'd1);

    always_comb begin
        byte_count_next = byte_count_reg;
        job_vld_next    = job_vld_reg;
        job_next        = job_reg;
        m_vld_next      = m_vld_reg;

        if (out_free) begin
            m_vld_next   = job_vld_reg;
            job_vld_next = 1'b0;
        end
        if (s_beat) begin
            byte_count_next = s_tlast ? 8'd0 : len_sat;
            if (s_tlast) begin
                job_vld_next    = 1'b1;
                job_next.known  = id_known;
                job_next.layout = id_layout;
                job_next.len    = len_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            job_vld_reg    <= 1'b0;
            m_vld_reg      <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            job_vld_reg    <= job_vld_next;
            m_vld_reg      <= m_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (s_beat && win_hit) begin
            win_reg[rel_pos[2:0]] <= s_tdata;
        end
        if (out_free && job_vld_reg) begin
            res_reg <= dec_res;
        end
    end

    bsad_decode u_decode (
        .job (job_reg),
        .win (win_reg),
        .res (dec_res)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {res_reg.battery_present, res_reg.battery_percent,
                       res_reg.humidity_tenths, res_reg.temp_centi};
    assign m_tuser  = {res_reg.layout, res_reg.status};

endmodule

`default_nettype wire

// ===== sv/bsad_checker.sv =====
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

`include "ble_sensor_advert_decoder_defines.svh"

module bsad_checker
    import bsad_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    // a failed packet carries no measurement
    `BSAD_ASSERT_SAME(a_fail_zero, (m_tvalid && (m_tuser[1:0] != ST_OK)) |-> (m_tdata == 32'd0))

    // an unknown maker always reports layout zero
    `BSAD_ASSERT_SAME(a_unknown_layout, (m_tvalid && (m_tuser[1:0] == ST_UNKNOWN)) |-> (m_tuser[3:2] == 2'd0))

    // a good result stays within the checked ranges
    `BSAD_ASSERT_SAME(a_ok_range, (m_tvalid && (m_tuser[1:0] == ST_OK)) |-> ((m_tdata[23:14] <= 10'd1000) && (m_tdata[30:24] <= 7'd100) && (m_tdata[31] || (m_tdata[30:24] == 7'd0))))

    // a stalled result holds
    `BSAD_ASSERT_NEXT(a_hold, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind ble_sensor_advert_decoder bsad_checker u_bsad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
